FILE: design/r2a_pkg.sv
// Shared types, constants and helper functions for the radix-to-ASCII digit unit.
// Used by r2a_front, r2a_back and radix_to_ascii_digits_unit; depends on nothing.
package r2a_pkg;

  // Number of value bits that take part in the conversion.
  localparam int VALUE_WIDTH = 64;

  // Digit store depth and the widths that follow from it.
  localparam int DIGIT_SLOTS = 64;
  localparam int DIGIT_IDX_W = $clog2(DIGIT_SLOTS);
  localparam int COUNT_W     = $clog2(DIGIT_SLOTS + 1);
  localparam int DIGIT_W     = 4;

  // Long division by the base walks the value a chunk of bits per cycle.
  localparam int DIV_BITS   = 8;
  localparam int DIV_CHUNKS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int PAD_W      = DIV_CHUNKS * DIV_BITS;
  localparam int CHUNK_W    = (DIV_CHUNKS > 1) ? $clog2(DIV_CHUNKS) : 1;

  // Command queue between front and back; depth is a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Field widths and base limits.
  localparam int RADIX_W   = 5;
  localparam int CHAR_W    = 7;
  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

  // ASCII anchors for the glyph mapping.
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = CHAR_W'(65);
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = CHAR_W'(97);

  // Input word as it arrives on the port.
  typedef struct packed {
    logic [63:0]        value;
    logic [RADIX_W-1:0] radix;
    logic               lower_case;
  } in_item_t;

  // Result word: one character.
  typedef struct packed {
    logic [CHAR_W-1:0] ascii_char;
    logic              last_char;
  } out_item_t;

  // Classified command held in the queue.
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [RADIX_W-1:0]     base;
    logic                   lower_case;
  } cmd_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_RD,
    BK_OUT
  } back_state_t;

  // Result of one division chunk.
  typedef struct packed {
    logic [DIV_BITS-1:0] quot;
    logic [DIGIT_W-1:0]  rem;
  } div_step_t;

  // Restoring division of DIV_BITS value bits by the base, remainder carried in.
  function automatic div_step_t div_chunk(input logic [DIGIT_W-1:0]  rem_in,
                                          input logic [DIV_BITS-1:0] bits,
                                          input logic [RADIX_W-1:0]  base);
    div_step_t         res;
    logic [DIGIT_W:0]  trial;
    logic [DIGIT_W-1:0] rem;
    rem = rem_in;
    res.quot = '0;
    for (int i = DIV_BITS - 1; i >= 0; i--) begin
      trial = {rem, bits[i]};
      if (trial >= (DIGIT_W+1)'(base)) begin
        res.quot[i] = 1'b1;
        trial = trial - (DIGIT_W+1)'(base);
      end
      rem = trial[DIGIT_W-1:0];
    end
    res.rem = rem;
    return res;
  endfunction

  // ASCII code of one digit value.
  function automatic logic [CHAR_W-1:0] glyph_for(input logic [DIGIT_W-1:0] digit,
                                                  input logic lower);
    logic [CHAR_W-1:0] c;
    if (digit < DIGIT_W'(10)) begin
      c = CHAR_ZERO + CHAR_W'(digit);
    end else if (lower) begin
      c = CHAR_LOWER_A + CHAR_W'(digit - DIGIT_W'(10));
    end else begin
      c = CHAR_UPPER_A + CHAR_W'(digit - DIGIT_W'(10));
    end
    return c;
  endfunction

endpackage

FILE: design/radix_to_ascii_digits_unit.sv
// Each word passes through the queue; the back end then finds the digits one by one
// by chunked division by the base and sends each character out as a memory read,
// then a present state that holds until the receiver takes it. The back end
// converts one item at a time; the two-entry queue takes new words meanwhile.
// Synchronous active-low reset empties the queue and idles the back end.
module radix_to_ascii_digits_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  r2a_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output r2a_pkg::out_item_t out_data
);
  import r2a_pkg::*;

  logic q_valid;
  logic q_ready;
  cmd_t q_item;

  // Accept and classify.
  r2a_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  // Convert and emit.
  r2a_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: design/r2a_front.sv
// Front end of the radix-to-ASCII unit: accepts input words, clamps the base,
// masks the value and holds the commands in a short queue. Depends on r2a_pkg.
module r2a_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  r2a_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_ready,
  output r2a_pkg::cmd_t     q_item
);
  import r2a_pkg::*;

  cmd_t              q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   fill_r, fill_nxt;
  cmd_t              cmd;
  logic              push, pop;

  // Clamp the base into the supported range and keep the used value bits.
  always_comb begin
    cmd.value      = in_data.value[VALUE_WIDTH-1:0];
    cmd.lower_case = in_data.lower_case;
    if (in_data.radix < RADIX_MIN) begin
      cmd.base = RADIX_MIN;
    end else if (in_data.radix > RADIX_MAX) begin
      cmd.base = RADIX_MAX;
    end else begin
      cmd.base = in_data.radix;
    end
  end

  // Queue handshakes.
  assign in_ready = (fill_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid  = (fill_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Pointer and fill updates.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

FILE: design/r2a_back.sv
// Back end of the radix-to-ASCII unit: splits the value into digits by chunked
// long division, keeps them in a digit memory and emits them as ASCII. Uses r2a_pkg.
module r2a_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  r2a_pkg::cmd_t      q_item,
  output logic               out_valid,
  input  logic               out_ready,
  output r2a_pkg::out_item_t out_data
);
  import r2a_pkg::*;

  back_state_t            state_r, state_nxt;
  logic [PAD_W-1:0]       val_r;
  logic [DIGIT_W-1:0]     rem_r;
  logic [CHUNK_W-1:0]     chunk_r;
  logic [COUNT_W-1:0]     cnt_r;
  logic [RADIX_W-1:0]     base_r;
  logic                   lower_r;
  logic [DIGIT_IDX_W-1:0] idx_r;
  logic [DIGIT_W-1:0]     rd_data_r;
  logic [DIGIT_W-1:0]     digit_mem [DIGIT_SLOTS];

  div_step_t              step;
  logic [PAD_W-1:0]       val_nxt;
  logic                   chunk_last;
  logic                   more_digits;
  logic                   last_out;

  // One division chunk on the top bits of the running value.
  always_comb begin
    step        = div_chunk(rem_r, val_r[PAD_W-1 -: DIV_BITS], base_r);
    val_nxt     = (val_r << DIV_BITS) | PAD_W'(step.quot);
    chunk_last  = (chunk_r == CHUNK_W'(DIV_CHUNKS - 1));
    more_digits = (val_nxt != '0) && (cnt_r != COUNT_W'(DIGIT_SLOTS - 1));
    last_out    = (idx_r == '0);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) state_nxt = BK_DIV;
      end
      BK_DIV: begin
        if (chunk_last && !more_digits) state_nxt = BK_RD;
      end
      BK_RD: begin
        state_nxt = BK_OUT;
      end
      BK_OUT: begin
        if (out_ready) state_nxt = last_out ? BK_IDLE : BK_RD;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_ready             = 1'b0;
    out_valid           = 1'b0;
    out_data.ascii_char = glyph_for(rd_data_r, lower_r);
    out_data.last_char  = last_out;
    case (state_r)
      BK_IDLE: q_ready   = 1'b1;
      BK_OUT:  out_valid = 1'b1;
      default: begin
        q_ready   = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Division datapath and digit bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r   <= '0;
      rem_r   <= '0;
      chunk_r <= '0;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      case (state_r)
        BK_IDLE: begin
          if (q_valid) begin
            val_r   <= PAD_W'(q_item.value);
            base_r  <= q_item.base;
            lower_r <= q_item.lower_case;
            rem_r   <= '0;
            chunk_r <= '0;
            cnt_r   <= '0;
          end
        end
        BK_DIV: begin
          val_r <= val_nxt;
          if (chunk_last) begin
            rem_r   <= '0;
            chunk_r <= '0;
            cnt_r   <= cnt_r + 1'b1;
            idx_r   <= cnt_r[DIGIT_IDX_W-1:0];
          end else begin
            rem_r   <= step.rem;
            chunk_r <= chunk_r + 1'b1;
          end
        end
        BK_OUT: begin
          if (out_ready && !last_out) idx_r <= idx_r - 1'b1;
        end
        default: begin
          idx_r <= idx_r;
        end
      endcase
    end
  end

  // Digit memory: written once per finished digit, read once per character.
  always_ff @(posedge clk) begin
    if (state_r == BK_DIV && chunk_last) begin
      digit_mem[cnt_r[DIGIT_IDX_W-1:0]] <= step.rem;
    end
    if (state_r == BK_RD) begin
      rd_data_r <= digit_mem[idx_r];
    end
  end

endmodule

FILE: tb/radix_to_ascii_digits_unit_tb.sv
// Self-checking testbench for radix_to_ascii_digits_unit: directed and random value/base words in,
// predicted ASCII digit stream checked character by character. Depends only on r2a_pkg and the RTL.
module radix_to_ascii_digits_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import r2a_pkg::*;

  localparam int  CYCLE_LIMIT   = 2_000_000;
  localparam int  RANDOM_WORDS  = 350;
  localparam int  HOLD_CYCLES   = 2000;
  localparam int  HOLD_AFTER    = 30;
  localparam int  DRAIN_CYCLES  = 100;
  localparam int  MAX_PRINTED   = 100;
  localparam int  CASE_SHIFT    = 32;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Words waiting to be offered and characters the block still owes us.
  in_item_t  pending_words[$];
  out_item_t expected_chars[$];
  out_item_t want_char;

  int  words_sent = 0;
  int  words_offered = 0;
  int  chars_seen = 0;
  int  mismatches = 0;
  int  cycle_count = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  logic hold_off = 1'b0;
  logic hold_done = 1'b0;

  radix_to_ascii_digits_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // ASCII code of one digit value, with letters folded to lowercase on request.
  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [3:0] digit,
                                                    input logic lower);
    logic [7:0] c;
    if (digit < 4'd10) begin
      c = 8'h30 + 8'(digit);
    end else begin
      c = 8'h41 + 8'(digit - 4'd10);
    end
    if (lower && c >= 8'h41 && c <= 8'h5A) begin
      c = c + 8'(CASE_SHIFT);
    end
    return c[CHAR_W-1:0];
  endfunction

  // Split one word into digits and queue the characters, most significant first.
  function automatic void predict_digits(input in_item_t w);
    logic [VALUE_WIDTH-1:0] rest;
    logic [63:0]            base;
    logic [3:0]             digs[DIGIT_SLOTS];
    int                     n;
    out_item_t              c;
    base = 64'(w.radix);
    if (base < 64'(RADIX_MIN)) begin
      base = 64'(RADIX_MIN);
    end
    if (base > 64'(RADIX_MAX)) begin
      base = 64'(RADIX_MAX);
    end
    rest = w.value[VALUE_WIDTH-1:0];
    n = 0;
    do begin
      digs[n] = 4'(64'(rest) % base);
      rest = VALUE_WIDTH'(64'(rest) / base);
      n++;
    end while (rest != '0 && n < DIGIT_SLOTS);
    for (int k = n - 1; k >= 0; k--) begin
      c.ascii_char = digit_ascii(digs[k], w.lower_case);
      c.last_char  = (k == 0);
      expected_chars.push_back(c);
    end
  endfunction

  // Wait draw for either side; every fifth stretch of 40 runs with no idling.
  function automatic int draw_wait(input int idx);
    if ((idx / 40) % 5 == 4) begin
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("[%0t] mismatch at char %0d: %s", $time, chars_seen, what);
    end
  endtask

  task automatic push_word(input logic [63:0] value, input int radix, input logic lower);
    in_item_t w;
    w.value      = value;
    w.radix      = RADIX_W'(radix);
    w.lower_case = lower;
    pending_words.push_back(w);
  endtask

  // Stimulus: a directed set, then random words.
  initial begin
    logic [63:0] v;
    int          r;
    int          pick;
    // Zero in two bases and both cases.
    push_word(64'd0, 10, 1'b0);
    push_word(64'd0, 2, 1'b1);
    // Full-width value in the smallest and largest base: 64 and 16 digits.
    push_word(ALL_ONES, 2, 1'b0);
    push_word(ALL_ONES, 16, 1'b0);
    push_word(ALL_ONES, 16, 1'b1);
    // Bases below two saturate up, bases above sixteen saturate down.
    push_word(64'd5, 0, 1'b0);
    push_word(64'h8000_0000_0000_0000, 1, 1'b1);
    push_word(64'hDEAD_BEEF_CAFE_F00D, 17, 1'b1);
    push_word(ALL_ONES, 31, 1'b0);
    push_word(64'd1, 16, 1'b0);
    // Every legal base once, alternating letter case.
    for (int b = 2; b <= 16; b++) begin
      push_word(64'h0123_4567_89AB_CDEF ^ 64'(b), b, b[0]);
    end
    // Random part: mostly shortened values so digit counts spread out.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      v = {$urandom(), $urandom()};
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        v = v >> $urandom_range(0, 63);
      end else if (pick < 8) begin
        v = 64'($urandom_range(0, 300));
      end
      if ($urandom_range(0, 4) == 0) begin
        r = $urandom_range(0, 31);
      end else begin
        r = $urandom_range(2, 16);
      end
      push_word(v, r, 1'($urandom_range(0, 1)));
    end
  end

  // Driver: offers pending words with a random gap between words.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_digits(in_data);
        words_sent <= words_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_words.pop_front();
          gap_left <= draw_wait(words_offered);
          words_offered++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off once HOLD_AFTER words are in, to back up the queue.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_off  <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_sent >= HOLD_AFTER) begin
      hold_off  <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      if (hold_left == 1) begin
        hold_off <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted character against the oldest expectation.
  always @(posedge clk) begin
    int nxt;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                  out_data.ascii_char, out_data.last_char));
      end else begin
        want_char = expected_chars.pop_front();
        if (out_data.ascii_char != want_char.ascii_char) begin
          report_mismatch($sformatf("ascii_char 0x%02h, expected 0x%02h",
                                    out_data.ascii_char, want_char.ascii_char));
        end
        if (out_data.last_char != want_char.last_char) begin
          report_mismatch($sformatf("last_char %0b, expected %0b",
                                    out_data.last_char, want_char.last_char));
        end
      end
      chars_seen <= chars_seen + 1;
      nxt = draw_wait(chars_seen);
      stall_left <= nxt;
      out_ready  <= (nxt == 0) && !hold_off;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= !hold_off;
    end
  end

  // Reset, then wait for the stream to drain and give the verdict.
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_words.size() > 0 || in_valid || expected_chars.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Converted %0d words into %0d characters across bases 0..31, both cases,",
             words_sent, chars_seen);
    $display("with random gaps, stalls and one long output hold-off; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog on the cycle counter.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
    end
    $display("timeout after %0d cycles, %0d characters still expected",
             cycle_count, expected_chars.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: radix_to_ascii_digits_unit.f
design/r2a_pkg.sv
design/r2a_front.sv
design/r2a_back.sv
design/radix_to_ascii_digits_unit.sv
tb/radix_to_ascii_digits_unit_tb.sv
